@@ hdl/priority_round_robin_task_scheduler_macros.svh @@
// ---------------------------------------------------------------------------
// priority_round_robin_task_scheduler_macros
// assertion shorthands for the scheduler, clocked on clk and
// disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// condition holds at every edge out of reset
`define PRRTS_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PRRTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hdl/prrts_pkg.sv @@
// ---------------------------------------------------------------------------
// prrts_pkg
// shared widths, command codes and defaults of the task scheduler
// ---------------------------------------------------------------------------
package prrts_pkg;

	localparam int unsigned TASK_SLOTS_DEF = 16;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned SLOT_F_W  = 4;
	localparam int unsigned PRIO_W    = 8;
	localparam int unsigned TICK_W    = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_SLEEP = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

endpackage

@@ hdl/prrts_cmd_if.sv @@
// ---------------------------------------------------------------------------
// prrts_cmd_if
// command channel of the scheduler: valid/ready plus one command word
// ---------------------------------------------------------------------------
interface prrts_cmd_if import prrts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [SLOT_F_W-1:0] task_slot;
	logic [PRIO_W-1:0]   task_priority;
	logic [TICK_W-1:0]   wake_tick;
	logic [TICK_W-1:0]   now_tick;

	modport source (
		output valid, command, task_slot, task_priority, wake_tick, now_tick,
		input  ready
	);
	modport sink (
		input  valid, command, task_slot, task_priority, wake_tick, now_tick,
		output ready
	);
endinterface

@@ hdl/prrts_res_if.sv @@
// ---------------------------------------------------------------------------
// prrts_res_if
// result channel of the scheduler: valid/ready plus one result word
// ---------------------------------------------------------------------------
interface prrts_res_if import prrts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                accepted;
	logic [SLOT_F_W-1:0] result_slot;
	logic [PRIO_W-1:0]   picked_priority;

	modport source (
		output valid, accepted, result_slot, picked_priority,
		input  ready
	);
	modport sink (
		input  valid, accepted, result_slot, picked_priority,
		output ready
	);
endinterface

@@ hdl/prrts_ram.sv @@
// ---------------------------------------------------------------------------
// prrts_ram
// generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
module prrts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/priority_round_robin_task_scheduler.sv @@
// ---------------------------------------------------------------------------
// priority_round_robin_task_scheduler
// task table with add, sleep and tick commands; a tick wakes due tasks and
// picks the most urgent ready task, round-robin among equal priorities
//
//   channel  dir  handshake      word
//   cmd      in   valid/ready    command, task_slot, task_priority,
//                                wake_tick, now_tick
//   res      out  valid/ready    accepted, result_slot, picked_priority
//
// add, sleep and unknown commands go from idle straight to done; a tick
// makes one wake-and-max pass and, if a ready task is found, one round-robin
// pass over the table, each issuing one table entry a cycle to the entry RAMs
// one command at a time; cmd.ready is high only while idle, a finished
// word sits in the output register so the next command can be taken
// while res is stalled; arst_n clears table use, blocked flags and picks
// ---------------------------------------------------------------------------
`include "priority_round_robin_task_scheduler_macros.svh"

module priority_round_robin_task_scheduler import prrts_pkg::*; #(
	parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	prrts_cmd_if.sink   cmd,
	prrts_res_if.source res
);

	localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
	localparam int unsigned CNT_W  = $clog2(TASK_SLOTS + 1);
	localparam int unsigned CMP_W  = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAKE,
		ST_PICK,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SLOT_W-1:0]   last_q;
	logic                any_q;
	logic [TASK_SLOTS-1:0] blocked_q;
	logic [TICK_W-1:0]   now_q;
	logic [CNT_W-1:0]    issue_q;
	logic [SLOT_W-1:0]   addr_q;
	logic                v_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic [PRIO_W-1:0]   best_q;
	logic                found_q;
	logic                res_ok_q;
	logic [SLOT_F_W-1:0] res_slot_q;
	logic [PRIO_W-1:0]   res_prio_q;
	logic                out_valid_q;
	logic                out_ok_q;
	logic [SLOT_F_W-1:0] out_slot_q;
	logic [PRIO_W-1:0]   out_prio_q;

	logic [PRIO_W-1:0]   prio_rd;
	logic [TICK_W-1:0]   wake_rd;
	logic                table_free;
	logic                slot_ok;
	logic                add_we;
	logic                sleep_we;
	logic                scan_issue;
	logic                ent_blk;
	logic                woke;
	logic                ent_ready;
	logic [CNT_W-1:0]    last_inc;
	logic [CNT_W-1:0]    addr_inc;
	logic [SLOT_W-1:0]   start_idx;
	logic [SLOT_W-1:0]   addr_wrap;

	assign cmd.ready = (state_q == ST_IDLE);
	assign res.valid           = out_valid_q;
	assign res.accepted        = out_ok_q;
	assign res.result_slot     = out_slot_q;
	assign res.picked_priority = out_prio_q;

	assign table_free = cnt_q < CNT_W'(TASK_SLOTS);
	assign slot_ok    = CMP_W'(cmd.task_slot) < CMP_W'(cnt_q);
	assign add_we     = cmd.valid && cmd.ready
		&& (cmd_t'(cmd.command) == CMD_ADD) && table_free;
	assign sleep_we   = cmd.valid && cmd.ready
		&& (cmd_t'(cmd.command) == CMD_SLEEP) && slot_ok;

	// one entry issued to the RAMs per cycle, its data back in the cycle after
	assign scan_issue = issue_q < cnt_q;

	assign ent_blk   = blocked_q[idx_s1];
	assign woke      = ent_blk && (now_q >= wake_rd);
	assign ent_ready = !ent_blk || woke;

	// round-robin start just after the last pick, wrapping at the table end
	assign last_inc  = CNT_W'(last_q) + 1'b1;
	assign start_idx = (any_q && (last_inc != cnt_q)) ? SLOT_W'(last_inc) : '0;
	assign addr_inc  = CNT_W'(addr_q) + 1'b1;
	assign addr_wrap = (addr_inc == cnt_q) ? '0 : SLOT_W'(addr_inc);

	prrts_ram #(
		.WIDTH (PRIO_W),
		.DEPTH (TASK_SLOTS)
	) u_prio_ram (
		.clk   (clk),
		.we    (add_we),
		.waddr (SLOT_W'(cnt_q)),
		.wdata (cmd.task_priority),
		.raddr (addr_q),
		.rdata (prio_rd)
	);

	prrts_ram #(
		.WIDTH (TICK_W),
		.DEPTH (TASK_SLOTS)
	) u_wake_ram (
		.clk   (clk),
		.we    (sleep_we),
		.waddr (SLOT_W'(cmd.task_slot)),
		.wdata (cmd.wake_tick),
		.raddr (addr_q),
		.rdata (wake_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= '0;
			any_q       <= 1'b0;
			blocked_q   <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						now_q      <= cmd.now_tick;
						found_q    <= 1'b0;
						best_q     <= '0;
						issue_q    <= '0;
						addr_q     <= '0;
						v_s1       <= 1'b0;
						res_ok_q   <= 1'b0;
						res_slot_q <= '0;
						res_prio_q <= '0;
						state_q    <= ST_DONE;
						case (cmd_t'(cmd.command))
							CMD_ADD: begin
								if (table_free) begin
									blocked_q[SLOT_W'(cnt_q)] <= 1'b0;
									cnt_q      <= cnt_q + 1'b1;
									res_ok_q   <= 1'b1;
									res_slot_q <= SLOT_F_W'(cnt_q);
								end
							end
							CMD_SLEEP: begin
								if (slot_ok) begin
									blocked_q[SLOT_W'(cmd.task_slot)] <= 1'b1;
									res_ok_q   <= 1'b1;
									res_slot_q <= cmd.task_slot;
								end
							end
							CMD_TICK: begin
								state_q <= ST_WAKE;
							end
							default: ;
						endcase
					end
				end
				ST_WAKE: begin
					// wake due entries and track the highest ready priority
					v_s1   <= scan_issue;
					idx_s1 <= addr_q;
					if (scan_issue) begin
						addr_q  <= SLOT_W'(addr_inc);
						issue_q <= issue_q + 1'b1;
					end
					if (v_s1) begin
						if (woke) begin
							blocked_q[idx_s1] <= 1'b0;
						end
						if (ent_ready && (!found_q || prio_rd > best_q)) begin
							best_q  <= prio_rd;
							found_q <= 1'b1;
						end
					end else if (!scan_issue) begin
						issue_q <= '0;
						addr_q  <= start_idx;
						state_q <= found_q ? ST_PICK : ST_DONE;
					end
				end
				ST_PICK: begin
					v_s1   <= scan_issue;
					idx_s1 <= addr_q;
					if (scan_issue) begin
						addr_q  <= addr_wrap;
						issue_q <= issue_q + 1'b1;
					end
					if (v_s1 && !ent_blk && (prio_rd == best_q)) begin
						res_ok_q   <= 1'b1;
						res_slot_q <= SLOT_F_W'(idx_s1);
						res_prio_q <= best_q;
						last_q     <= idx_s1;
						any_q      <= 1'b1;
						v_s1       <= 1'b0;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_slot_q  <= res_slot_q;
						out_prio_q  <= res_prio_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// table never grows past its size
	`PRRTS_ASSERT_NOW(a_count_bound, cnt_q <= CNT_W'(TASK_SLOTS), "task count overflow")
	// the last pick always names an entry in use
	`PRRTS_ASSERT_IMP(a_last_in_table, any_q, CNT_W'(last_q) < cnt_q, "last pick out of table")
	// once a ready maximum is known, the round-robin pass must hit it
	`PRRTS_ASSERT_IMP(a_pick_not_dry, state_q == ST_PICK, scan_issue || v_s1, "pick pass ran dry")

endmodule

@@ bench/prrts_pick_checker.sv @@
// ---------------------------------------------------------------------------
// prrts_pick_checker
// watches the command and result channels of the task scheduler, keeps its
// own copy of the task table, works out the answer word of every command
// taken and compares each result word with the oldest answer still due
// ---------------------------------------------------------------------------
module prrts_pick_checker import prrts_pkg::*; #(
	parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	prrts_cmd_if  cmd,
	prrts_res_if  res,
	output int    fail_count,
	output int    pending
);

	typedef struct packed {
		logic                accepted;
		logic [SLOT_F_W-1:0] result_slot;
		logic [PRIO_W-1:0]   picked_priority;
	} answer_t;

	logic [PRIO_W-1:0] prio_tbl [TASK_SLOTS];
	logic              asleep   [TASK_SLOTS];
	logic [TICK_W-1:0] wake_tbl [TASK_SLOTS];
	int unsigned       used;
	int unsigned       last_pick;
	logic              picked_once;
	answer_t           answers_due [$];
	answer_t           want;
	int                fails = 0;

	function automatic answer_t predict_answer(
		input logic [CMD_W-1:0]    op,
		input logic [SLOT_F_W-1:0] slot,
		input logic [PRIO_W-1:0]   prio,
		input logic [TICK_W-1:0]   wake,
		input logic [TICK_W-1:0]   now
	);
		answer_t           ans;
		logic [PRIO_W-1:0] top_prio;
		logic              found;
		logic              done;
		int unsigned       first;
		int unsigned       idx;
		ans      = '0;
		top_prio = '0;
		found    = 1'b0;
		done     = 1'b0;
		case (op)
			CMD_ADD: begin
				if (used < TASK_SLOTS) begin
					prio_tbl[used]  = prio;
					asleep[used]    = 1'b0;
					ans.accepted    = 1'b1;
					ans.result_slot = SLOT_F_W'(used);
					used++;
				end
			end
			CMD_SLEEP: begin
				if (int'(slot) < used) begin
					asleep[slot]    = 1'b1;
					wake_tbl[slot]  = wake;
					ans.accepted    = 1'b1;
					ans.result_slot = slot;
				end
			end
			CMD_TICK: begin
				// plain unsigned compare, a wrapped wake tick is due at once
				for (int i = 0; i < used; i++)
					if (asleep[i] && now >= wake_tbl[i])
						asleep[i] = 1'b0;
				for (int i = 0; i < used; i++) begin
					if (!asleep[i] && (!found || prio_tbl[i] > top_prio)) begin
						top_prio = prio_tbl[i];
						found    = 1'b1;
					end
				end
				if (found) begin
					first = picked_once ? (last_pick + 1) % used : 0;
					for (int k = 0; k < used; k++) begin
						idx = (first + k) % used;
						if (!done && !asleep[idx] && prio_tbl[idx] == top_prio) begin
							done                = 1'b1;
							last_pick           = idx;
							picked_once         = 1'b1;
							ans.accepted        = 1'b1;
							ans.result_slot     = SLOT_F_W'(idx);
							ans.picked_priority = top_prio;
						end
					end
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	function automatic void check_field(input string name, input logic [PRIO_W-1:0] exp_v,
		input logic [PRIO_W-1:0] got_v);
		if (got_v !== exp_v) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				prio_tbl[i] = '0;
				asleep[i]   = 1'b0;
				wake_tbl[i] = '0;
			end
			used        = 0;
			last_pick   = 0;
			picked_once = 1'b0;
		end else begin
			if (cmd.valid && cmd.ready)
				answers_due.push_back(predict_answer(cmd.command, cmd.task_slot,
					cmd.task_priority, cmd.wake_tick, cmd.now_tick));
			if (res.valid && res.ready) begin
				if (answers_due.size() == 0) begin
					fails++;
					$display("%0t: result word with nothing due, expected none, got %0b/%0h/%0h",
						$time, res.accepted, res.result_slot, res.picked_priority);
				end else begin
					want = answers_due.pop_front();
					check_field("accepted", PRIO_W'(want.accepted), PRIO_W'(res.accepted));
					check_field("result_slot", PRIO_W'(want.result_slot),
						PRIO_W'(res.result_slot));
					check_field("picked_priority", want.picked_priority, res.picked_priority);
				end
			end
		end
		fail_count <= fails;
		pending    <= answers_due.size();
	end

endmodule

@@ bench/tb_priority_round_robin_task_scheduler.sv @@
// ---------------------------------------------------------------------------
// tb_priority_round_robin_task_scheduler
// drives add, sleep, tick and unknown command words into the scheduler under
// several idle and stall patterns; a directed opening covers the empty and
// three-task table, refused sleeps, ties and wake edges, then random traffic
// fills the table and keeps tasks sleeping and waking close below a tick wrap
// ---------------------------------------------------------------------------
module tb_priority_round_robin_task_scheduler;
	import prrts_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned RANDOM_WORDS = 1400;

	logic              clk;
	logic              arst_n;
	int                fail_count;
	int                pending;
	int unsigned       cycles = 0;
	int unsigned       gap_pct;
	int unsigned       stall_pct;
	int unsigned       tasks_sent;
	logic [TICK_W-1:0] tick_base;

	prrts_cmd_if cmd ();
	prrts_res_if res ();

	priority_round_robin_task_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	prrts_pick_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_priority_round_robin_task_scheduler failed");
			$finish;
		end
	end

	always @(posedge clk)
		res.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	task automatic send_word(
		input logic [CMD_W-1:0]    op,
		input logic [SLOT_F_W-1:0] slot,
		input logic [PRIO_W-1:0]   prio,
		input logic [TICK_W-1:0]   wake,
		input logic [TICK_W-1:0]   now
	);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			cmd.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		cmd.valid         <= 1'b1;
		cmd.command       <= op;
		cmd.task_slot     <= slot;
		cmd.task_priority <= prio;
		cmd.wake_tick     <= wake;
		cmd.now_tick      <= now;
		do @(posedge clk); while (!cmd.ready);
		if (op == CMD_ADD)
			tasks_sent++;
	endtask

	task automatic send_random_word();
		int unsigned       roll;
		int unsigned       used;
		logic [CMD_W-1:0]  op;
		logic [SLOT_F_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
		logic [TICK_W-1:0] wake;
		logic [TICK_W-1:0] now;
		used = (tasks_sent < TASK_SLOTS_DEF) ? tasks_sent : TASK_SLOTS_DEF;
		roll = $urandom_range(99);
		slot = SLOT_F_W'($urandom);
		prio = PRIO_W'($urandom);
		wake = $urandom;
		now  = $urandom;
		// fill the table early, then only the odd refused add
		if (roll < ((used < TASK_SLOTS_DEF) ? 25 : 4))
			op = CMD_ADD;
		else if (roll < 50)
			op = CMD_SLEEP;
		else if (roll < 95)
			op = CMD_TICK;
		else
			op = CMD_UNKNOWN;
		case (op)
			CMD_ADD: begin
				// few distinct priorities so ties are common
				case ($urandom_range(3))
					0: prio = '0;
					1: prio = '1;
					2: prio = 8'h80;
					default: ;
				endcase
			end
			CMD_SLEEP: begin
				if (used != 0 && $urandom_range(9) != 0)
					slot = SLOT_F_W'($urandom_range(used - 1));
				case ($urandom_range(19))
					0: wake = '0;
					1: wake = '1;
					2: ;
					default: wake = tick_base + $urandom_range(80);
				endcase
			end
			CMD_TICK: begin
				tick_base = tick_base + $urandom_range(12);
				if ($urandom_range(19) != 0)
					now = tick_base;
			end
			default: ;
		endcase
		send_word(op, slot, prio, wake, now);
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.command       = '0;
		cmd.task_slot     = '0;
		cmd.task_priority = '0;
		cmd.wake_tick     = '0;
		cmd.now_tick      = '0;
		res.ready         = 1'b0;
		gap_pct           = 0;
		stall_pct         = 0;
		tasks_sent        = 0;
		// start the tick count near the top of its range
		tick_base         = 32'hFFFF_E000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: nothing to pick, nothing to put to sleep
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd0);
		send_word(CMD_SLEEP, 4'd0, 8'd0, 32'd5, 32'd0);
		send_word(CMD_UNKNOWN, 4'hF, 8'hFF, '1, '1);
		send_word(CMD_ADD, 4'd0, 8'hFF, 32'd0, 32'd0);
		send_word(CMD_ADD, 4'hF, 8'h00, '1, '1);
		send_word(CMD_ADD, 4'd0, 8'hFF, 32'd0, 32'd0);
		// equal priorities rotate, wrapping past the last entry
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd0);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd1);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd2);
		send_word(CMD_SLEEP, 4'd0, 8'd0, 32'd100, 32'd0);
		send_word(CMD_SLEEP, 4'd2, 8'd0, '1, 32'd0);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd99);
		// sleeping again just moves the wake tick
		send_word(CMD_SLEEP, 4'd0, 8'd0, 32'd50, 32'd0);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd50);
		send_word(CMD_SLEEP, 4'hF, 8'd0, 32'd0, 32'd0);
		send_word(CMD_SLEEP, 4'd3, 8'd0, 32'd0, 32'd0);
		send_word(CMD_SLEEP, 4'd1, 8'd0, 32'd0, 32'd0);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, '1);
		// everything asleep: no pick, last pick kept
		send_word(CMD_SLEEP, 4'd0, 8'd0, 32'h8000_0000, 32'd0);
		send_word(CMD_SLEEP, 4'd1, 8'd0, 32'h8000_0000, 32'd0);
		send_word(CMD_SLEEP, 4'd2, 8'd0, 32'h8000_0000, 32'd0);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'd7);
		send_word(CMD_TICK, 4'd0, 8'd0, 32'd0, 32'h8000_0000);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct <= 0;  end
				1: begin gap_pct = 54; stall_pct <= 0;  end
				2: begin gap_pct = 0;  stall_pct <= 54; end
				default: begin gap_pct = 14; stall_pct <= 14; end
			endcase
			repeat (RANDOM_WORDS / 4) send_random_word();
		end

		cmd.valid <= 1'b0;
		stall_pct <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("tb_priority_round_robin_task_scheduler passed");
		else
			$display("tb_priority_round_robin_task_scheduler failed");
		$finish;
	end

endmodule

@@ priority_round_robin_task_scheduler.f @@
+incdir+hdl
hdl/prrts_pkg.sv
hdl/prrts_cmd_if.sv
hdl/prrts_res_if.sv
hdl/prrts_ram.sv
hdl/priority_round_robin_task_scheduler.sv
bench/prrts_pick_checker.sv
bench/tb_priority_round_robin_task_scheduler.sv
